// ----- hdl/art_pkg.sv -----
// ----------------------------------------------------------------------------
// art_pkg
// Shared types, codes and constants of the fragment reassembly tracker.
// ----------------------------------------------------------------------------
package art_pkg;

	// Number of per-source reassembly contexts.
	localparam int SOURCE_COUNT = 256;
	localparam int SLOT_W       = (SOURCE_COUNT > 1) ? $clog2(SOURCE_COUNT) : 1;
	localparam int ADDR_RANGE   = 256;

	// A first split flag of all ones selects the second header.
	localparam logic [7:0] EXC_FLAG = 8'hff;

	localparam logic [7:0] OLD_IP_RESET   = 8'd240;
	localparam logic [7:0] OLD_ARP_RESET  = 8'd241;
	localparam logic [7:0] DIAGNOSE_RESET = 8'd128;

	typedef enum logic [1:0] {
		CFG_OLD_IP   = 2'd0,
		CFG_OLD_ARP  = 2'd1,
		CFG_DIAGNOSE = 2'd2,
		CFG_UNUSED   = 2'd3
	} cfg_index_t;

	typedef enum logic [2:0] {
		ACT_RAW      = 3'd0,
		ACT_UNFRAG   = 3'd1,
		ACT_FIRST    = 3'd2,
		ACT_APPEND   = 3'd3,
		ACT_COMPLETE = 3'd4,
		ACT_DUP      = 3'd5,
		ACT_OOS      = 3'd6
	} action_t;

	typedef enum logic [2:0] {
		WHY_NONE    = 3'd0,
		WHY_NOFIRST = 3'd1,
		WHY_SEQ     = 3'd2,
		WHY_TYPE    = 3'd3,
		WHY_DEST    = 3'd4,
		WHY_OTHER   = 3'd5
	} reason_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EVAL = 1'b1
	} state_t;

	// One stored reassembly context, without its valid bit.
	typedef struct packed {
		logic [7:0]  max_flag;
		logic [7:0]  last_seen;
		logic [15:0] seq_id;
		logic [7:0]  frame_type;
		logic [7:0]  dest;
	} ctx_t;

	localparam int CTX_W = $bits(ctx_t);

	typedef struct packed {
		logic capture;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic out_busy;
	} status_t;

	typedef logic [SLOT_W-1:0] slot_idx_t;
	typedef slot_idx_t slot_map_t [ADDR_RANGE];

	// Station address to context slot, wrapping at the table depth.
	function automatic slot_map_t build_slot_map();
		slot_map_t m;
		int c;
		c = 0;
		for (int i = 0; i < ADDR_RANGE; i++) begin
			m[i] = SLOT_W'(c);
			c = (c == SOURCE_COUNT - 1) ? 0 : c + 1;
		end
		return m;
	endfunction

	localparam slot_map_t SLOT_MAP = build_slot_map();

endpackage

// ----- hdl/art_ram.sv -----
// ----------------------------------------------------------------------------
// art_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module art_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  logic [WIDTH-1:0]           wdata,
	input  logic                       re,
	input  logic [$clog2(DEPTH)-1:0]   raddr,
	output logic [WIDTH-1:0]           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hdl/art_ctrl.sv -----
// ----------------------------------------------------------------------------
// art_ctrl
// Sequencer: takes one header, evaluates it, commits it once the output is free.
// ----------------------------------------------------------------------------
module art_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  art_pkg::status_t  status,
	output art_pkg::cmd_t     cmd
);
	import art_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (!status.out_busy) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.capture = 1'b0;
		cmd.commit  = 1'b0;
		in_stall    = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall    = 1'b0;
				cmd.capture = in_valid;
			end
			ST_EVAL: begin
				// The result register must be free before the context is updated.
				cmd.commit = !status.out_busy;
			end
			default: in_stall = 1'b1;
		endcase
	end

endmodule

// ----- hdl/art_datapath.sv -----
// ----------------------------------------------------------------------------
// art_datapath
// Header registers, context table, decision logic and the result register.
// ----------------------------------------------------------------------------
module art_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [7:0]        cfg_data,
	input  logic [7:0]        source_address,
	input  logic [7:0]        dest_address,
	input  logic [7:0]        frame_type,
	input  logic [7:0]        split_flag,
	input  logic [15:0]       sequence_id,
	input  logic [7:0]        ext_split_flag,
	input  logic [15:0]       ext_sequence_id,
	input  art_pkg::cmd_t     cmd,
	output art_pkg::status_t  status,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [2:0]        action,
	output logic [2:0]        reject_reason,
	output logic              held_discarded,
	output logic [6:0]        fragment_index
);
	import art_pkg::*;

	logic [7:0] old_ip_q;
	logic [7:0] old_arp_q;
	logic [7:0] diagnose_q;

	slot_idx_t   slot_q;
	logic [7:0]  dest_q;
	logic [7:0]  type_q;
	logic [7:0]  flag_q;
	logic [15:0] seq_q;

	logic [SOURCE_COUNT-1:0] valid_q;
	logic [CTX_W-1:0]        ram_rdata;
	ctx_t                    rd_ctx;
	ctx_t                    wr_ctx;
	logic                    ctx_hit;
	logic                    is_raw;

	action_t    act_d;
	reason_t    why_d;
	logic       drop_d;
	logic [6:0] idx_d;
	logic       wr_en;
	logic       set_valid;
	logic       clr_valid;

	logic       out_valid_q;
	action_t    action_q;
	reason_t    reason_q;
	logic       drop_q;
	logic [6:0] index_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			old_ip_q   <= OLD_IP_RESET;
			old_arp_q  <= OLD_ARP_RESET;
			diagnose_q <= DIAGNOSE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_OLD_IP:   old_ip_q   <= cfg_data;
				CFG_OLD_ARP:  old_arp_q  <= cfg_data;
				CFG_DIAGNOSE: diagnose_q <= cfg_data;
				default:      old_ip_q   <= old_ip_q;
			endcase
		end
	end

	// Header capture; the exception format is resolved here.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			slot_q <= SLOT_MAP[source_address];
			dest_q <= dest_address;
			type_q <= frame_type;
			if (split_flag == EXC_FLAG) begin
				flag_q <= ext_split_flag;
				seq_q  <= ext_sequence_id;
			end else begin
				flag_q <= split_flag;
				seq_q  <= sequence_id;
			end
		end
	end

	art_ram #(
		.WIDTH (CTX_W),
		.DEPTH (SOURCE_COUNT)
	) u_ctx_ram (
		.clk   (clk),
		.we    (cmd.commit && wr_en),
		.waddr (slot_q),
		.wdata (wr_ctx),
		.re    (cmd.capture),
		.raddr (SLOT_MAP[source_address]),
		.rdata (ram_rdata)
	);

	assign rd_ctx  = ctx_t'(ram_rdata);
	assign ctx_hit = valid_q[slot_q];
	assign is_raw  = (type_q == old_ip_q) || (type_q == old_arp_q) || (type_q == diagnose_q);

	always_comb begin
		act_d     = ACT_RAW;
		why_d     = WHY_NONE;
		drop_d    = 1'b0;
		idx_d     = flag_q[7:1];
		wr_en     = 1'b0;
		wr_ctx    = rd_ctx;
		set_valid = 1'b0;
		clr_valid = 1'b0;
		priority if (is_raw) begin
			idx_d = '0;
		end else if (flag_q[0]) begin
			// An odd flag opens a fresh context and drops whatever was held.
			act_d             = ACT_FIRST;
			drop_d            = ctx_hit;
			wr_en             = 1'b1;
			set_valid         = 1'b1;
			wr_ctx.max_flag   = flag_q;
			wr_ctx.last_seen  = '0;
			wr_ctx.seq_id     = seq_q;
			wr_ctx.frame_type = type_q;
			wr_ctx.dest       = dest_q;
		end else if (flag_q == 8'd0) begin
			act_d = ACT_UNFRAG;
		end else if (!ctx_hit) begin
			act_d = ACT_OOS;
			why_d = WHY_NOFIRST;
		end else begin
			priority if (seq_q != rd_ctx.seq_id) begin
				why_d = WHY_SEQ;
			end else if (type_q != rd_ctx.frame_type) begin
				why_d = WHY_TYPE;
			end else if (dest_q != rd_ctx.dest) begin
				why_d = WHY_DEST;
			end else begin
				why_d = WHY_NONE;
			end

			priority if (why_d != WHY_NONE) begin
				act_d = ACT_OOS;
			end else if (flag_q == rd_ctx.last_seen) begin
				act_d = ACT_DUP;
			end else if ({1'b0, flag_q} == ({1'b0, rd_ctx.last_seen} + 9'd2)) begin
				wr_en            = 1'b1;
				wr_ctx.last_seen = flag_q;
				if (flag_q > rd_ctx.max_flag) begin
					act_d     = ACT_COMPLETE;
					clr_valid = 1'b1;
				end else begin
					act_d = ACT_APPEND;
				end
			end else begin
				act_d = ACT_OOS;
				why_d = WHY_OTHER;
			end

			if (act_d == ACT_OOS) begin
				clr_valid = 1'b1;
				drop_d    = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.commit) begin
			if (set_valid) begin
				valid_q[slot_q] <= 1'b1;
			end else if (clr_valid) begin
				valid_q[slot_q] <= 1'b0;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			action_q <= act_d;
			reason_q <= why_d;
			drop_q   <= drop_d;
			index_q  <= idx_d;
		end
	end

	assign status.out_busy = out_valid_q && out_stall;
	assign out_valid       = out_valid_q;
	assign action          = action_q;
	assign reject_reason   = reason_q;
	assign held_discarded  = drop_q;
	assign fragment_index  = index_q;

`ifndef ASSERT_OFF
	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !(out_valid_q && out_stall))
		else $error("result overwritten while stalled");

	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q)
		else $error("committed result not presented");

	a_complete_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && (act_d == ACT_COMPLETE)) |=> !valid_q[$past(slot_q)])
		else $error("completed context still valid");

	a_first_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && (act_d == ACT_FIRST)) |=> valid_q[$past(slot_q)])
		else $error("first fragment did not open a context");
`endif

endmodule

// ----- hdl/arcnet_reassembly_tracker_top.sv -----
// ----------------------------------------------------------------------------
// arcnet_reassembly_tracker_top
// Per-source tracker of fragmented ARCnet packet reassembly.
// ----------------------------------------------------------------------------
// Usage:
// Each request on the input channel carries the header of one received
// fragment; in_stall is raised while a header is being evaluated. Each header
// yields exactly one result on the output channel: the action taken, the
// reason of a rejection, whether a held partial packet was discarded, and the
// fragment position.
// A header is taken in the idle state and its result is registered when it
// commits from the evaluate state; no new header is taken until then. This
// comes from the context memory: one registered read, then one write of the
// same entry, per fragment.
// The result waits in an output register; while out_stall holds it, the
// evaluated header stays pending and in_stall stays high.
// The configuration channel is always ready; a write to an index beyond the
// three type registers is ignored. Writes belong to idle periods.
// Reset clears every context's valid bit at once and loads the default type
// codes; no clearing pass is needed.
// ----------------------------------------------------------------------------
module arcnet_reassembly_tracker_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  source_address,
	input  logic [7:0]  dest_address,
	input  logic [7:0]  frame_type,
	input  logic [7:0]  split_flag,
	input  logic [15:0] sequence_id,
	input  logic [7:0]  ext_split_flag,
	input  logic [15:0] ext_sequence_id,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  action,
	output logic [2:0]  reject_reason,
	output logic        held_discarded,
	output logic [6:0]  fragment_index
);
	import art_pkg::*;

	cmd_t    cmd;
	status_t status;

	assign cfg_ready = 1'b1;

	art_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	art_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_valid && cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.source_address  (source_address),
		.dest_address    (dest_address),
		.frame_type      (frame_type),
		.split_flag      (split_flag),
		.sequence_id     (sequence_id),
		.ext_split_flag  (ext_split_flag),
		.ext_sequence_id (ext_sequence_id),
		.cmd             (cmd),
		.status          (status),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.action          (action),
		.reject_reason   (reject_reason),
		.held_discarded  (held_discarded),
		.fragment_index  (fragment_index)
	);

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the per-source fragment reassembly tracker.
// A scoreboard class tracks the per-source contexts and the type registers,
// predicts the verdict of every header request the block accepts and checks
// each result against the oldest pending prediction. Directed headers cover
// the special cases. Random phases follow under several register settings,
// made mostly of well-formed fragment trains with random faults mixed in.
// ----------------------------------------------------------------------------
module tb;
	import art_pkg::*;

	localparam int QUIET_LIMIT = 4000;

	typedef struct {
		logic [7:0]  src;
		logic [7:0]  dst;
		logic [7:0]  typ;
		logic [7:0]  flag;
		logic [15:0] seq;
		logic [7:0]  xflag;
		logic [15:0] xseq;
	} header_t;

	typedef struct {
		action_t    act;
		reason_t    why;
		logic       drop;
		logic [6:0] pos;
	} verdict_t;

	class fragment_scoreboard;
		logic [7:0] raw_types [3];
		bit         live [SOURCE_COUNT];
		ctx_t       ctx_mem [SOURCE_COUNT];
		verdict_t   pending [$];
		int         errors;

		function new();
			raw_types = '{OLD_IP_RESET, OLD_ARP_RESET, DIAGNOSE_RESET};
			foreach (live[i]) begin
				live[i] = 1'b0;
				ctx_mem[i] = '0;
			end
			errors = 0;
		endfunction

		function void write_reg(cfg_index_t idx, logic [7:0] val);
			case (idx)
				CFG_OLD_IP:   raw_types[0] = val;
				CFG_OLD_ARP:  raw_types[1] = val;
				CFG_DIAGNOSE: raw_types[2] = val;
				default: ;
			endcase
		endfunction

		function bit is_raw(logic [7:0] t);
			return t == raw_types[0] || t == raw_types[1] || t == raw_types[2];
		endfunction

		function logic [7:0] pick_plain_type();
			logic [7:0] t;
			do t = 8'($urandom); while (is_raw(t));
			return t;
		endfunction

		function void note_header(header_t h);
			verdict_t   v;
			logic [7:0]  f;
			logic [15:0] s;
			int          slot;
			v.act = ACT_RAW;
			v.why = WHY_NONE;
			v.drop = 1'b0;
			v.pos = 7'd0;
			if (!is_raw(h.typ)) begin
				f = h.flag;
				s = h.seq;
				// The exception format moves the real flag and id to the second header.
				if (h.flag == EXC_FLAG) begin
					f = h.xflag;
					s = h.xseq;
				end
				v.pos = f[7:1];
				slot = int'(h.src) % SOURCE_COUNT;
				if (f[0]) begin
					v.drop = live[slot];
					live[slot] = 1'b1;
					ctx_mem[slot] = '{max_flag: f, last_seen: 8'd0, seq_id: s,
						frame_type: h.typ, dest: h.dst};
					v.act = ACT_FIRST;
				end else if (f == 8'd0) begin
					v.act = ACT_UNFRAG;
				end else if (!live[slot]) begin
					v.act = ACT_OOS;
					v.why = WHY_NOFIRST;
				end else begin
					if (s != ctx_mem[slot].seq_id)
						v.why = WHY_SEQ;
					else if (h.typ != ctx_mem[slot].frame_type)
						v.why = WHY_TYPE;
					else if (h.dst != ctx_mem[slot].dest)
						v.why = WHY_DEST;
					if (v.why != WHY_NONE) begin
						v.act = ACT_OOS;
					end else if (f == ctx_mem[slot].last_seen) begin
						v.act = ACT_DUP;
					end else if ({1'b0, f} == {1'b0, ctx_mem[slot].last_seen} + 9'd2) begin
						ctx_mem[slot].last_seen = f;
						if (f > ctx_mem[slot].max_flag) begin
							live[slot] = 1'b0;
							v.act = ACT_COMPLETE;
						end else begin
							v.act = ACT_APPEND;
						end
					end else begin
						v.act = ACT_OOS;
						v.why = WHY_OTHER;
					end
					if (v.act == ACT_OOS) begin
						live[slot] = 1'b0;
						v.drop = 1'b1;
					end
				end
			end
			pending.push_back(v);
		endfunction

		function void check_verdict(logic [2:0] act, logic [2:0] why, logic drop,
				logic [6:0] pos);
			verdict_t v;
			if (pending.size() == 0) begin
				$display("%0t: result with no request pending: action %0d reason %0d",
					$time, act, why);
				errors++;
				return;
			end
			v = pending.pop_front();
			if (act !== v.act) begin
				$display("%0t: action expected %0d got %0d", $time, v.act, act);
				errors++;
			end
			if (why !== v.why) begin
				$display("%0t: reject_reason expected %0d got %0d", $time, v.why, why);
				errors++;
			end
			if (drop !== v.drop) begin
				$display("%0t: held_discarded expected %0d got %0d", $time, v.drop, drop);
				errors++;
			end
			if (pos !== v.pos) begin
				$display("%0t: fragment_index expected %0d got %0d", $time, v.pos, pos);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [7:0]  cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  source_address;
	logic [7:0]  dest_address;
	logic [7:0]  frame_type;
	logic [7:0]  split_flag;
	logic [15:0] sequence_id;
	logic [7:0]  ext_split_flag;
	logic [15:0] ext_sequence_id;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  action;
	logic [2:0]  reject_reason;
	logic        held_discarded;
	logic [6:0]  fragment_index;

	fragment_scoreboard sb;
	bit calm = 1'b0;
	int quiet_cycles = 0;

	arcnet_reassembly_tracker_top DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.source_address  (source_address),
		.dest_address    (dest_address),
		.frame_type      (frame_type),
		.split_flag      (split_flag),
		.sequence_id     (sequence_id),
		.ext_split_flag  (ext_split_flag),
		.ext_sequence_id (ext_sequence_id),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.action          (action),
		.reject_reason   (reject_reason),
		.held_discarded  (held_discarded),
		.fragment_index  (fragment_index)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Receiver stalls come in bursts; they stop once the run turns calm.
	initial begin
		out_stall <= 1'b0;
		@(posedge clk);
		forever begin
			out_stall <= !calm && ($urandom_range(0, 2) == 0);
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.note_header('{source_address, dest_address, frame_type, split_flag,
				sequence_id, ext_split_flag, ext_sequence_id});
		if (arst_n && cfg_valid && cfg_ready)
			sb.write_reg(cfg_index_t'(cfg_index), cfg_data);
		if (arst_n && out_valid === 1'b1 && !out_stall)
			sb.check_verdict(action, reject_reason, held_discarded, fragment_index);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic header_t mk(logic [7:0] src, logic [7:0] dst, logic [7:0] typ,
			logic [7:0] flag, logic [15:0] seq, logic [7:0] xflag, logic [15:0] xseq);
		header_t h;
		h = '{src, dst, typ, flag, seq, xflag, xseq};
		return h;
	endfunction

	function automatic header_t random_header();
		return mk(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
			16'($urandom), 8'($urandom), 16'($urandom));
	endfunction

	// One fragment of a train, sent in either header format.
	function automatic header_t fragment(header_t base, logic [7:0] f);
		header_t h;
		h = base;
		if (f == EXC_FLAG || $urandom_range(0, 3) == 0) begin
			h.flag = EXC_FLAG;
			h.seq = 16'($urandom);
			h.xflag = f;
			h.xseq = base.seq;
		end else begin
			h.flag = f;
			h.xflag = 8'($urandom);
			h.xseq = 16'($urandom);
		end
		return h;
	endfunction

	task automatic send_header(input header_t h);
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 19);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		source_address <= h.src;
		dest_address <= h.dst;
		frame_type <= h.typ;
		split_flag <= h.flag;
		sequence_id <= h.seq;
		ext_split_flag <= h.xflag;
		ext_sequence_id <= h.xseq;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
	endtask

	// Lets every pending result arrive, then a few cycles more.
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_type_regs(input logic [7:0] ip, input logic [7:0] arp,
			input logic [7:0] diag);
		logic [7:0] vals [4];
		vals = '{ip, arp, diag, 8'($urandom)};
		for (int i = 0; i < 4; i++) begin
			cfg_index <= 2'(i);
			cfg_data <= vals[i];
			cfg_valid <= 1'b1;
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic run_directed();
		send_header(mk(8'd5, 8'd1, 8'd240, 8'd1, 16'd1, 8'd0, 16'd0));
		send_header(mk(8'd5, 8'd1, 8'd241, 8'd3, 16'd1, 8'd0, 16'd0));
		send_header(mk(8'd255, 8'd255, 8'd128, 8'd255, 16'hffff, 8'hff, 16'hffff));
		send_header(mk(8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 8'd0, 16'd0));
		// An even flag with no first fragment held.
		send_header(mk(8'd7, 8'd9, 8'd1, 8'd2, 16'hffff, 8'd0, 16'd0));
		send_header(mk(8'd7, 8'd9, 8'd1, 8'd5, 16'hffff, 8'd0, 16'd0));
		send_header(mk(8'd7, 8'd9, 8'd1, 8'd2, 16'hffff, 8'd0, 16'd0));
		send_header(mk(8'd7, 8'd9, 8'd1, 8'd2, 16'hffff, 8'd0, 16'd0));
		send_header(mk(8'd7, 8'd9, 8'd1, 8'd4, 16'hffff, 8'd0, 16'd0));
		send_header(mk(8'd7, 8'd9, 8'd1, 8'd6, 16'hffff, 8'd0, 16'd0));
		send_header(mk(8'd7, 8'd9, 8'd1, 8'd3, 16'd100, 8'd0, 16'd0));
		// A new first fragment throws away the held one.
		send_header(mk(8'd7, 8'd9, 8'd1, 8'd3, 16'd200, 8'd0, 16'd0));
		send_header(mk(8'd7, 8'd9, 8'd1, 8'd2, 16'd201, 8'd0, 16'd0));
		send_header(mk(8'd7, 8'd9, 8'd1, 8'd3, 16'd300, 8'd0, 16'd0));
		send_header(mk(8'd7, 8'd9, 8'd2, 8'd2, 16'd300, 8'd0, 16'd0));
		send_header(mk(8'd7, 8'd9, 8'd1, 8'd3, 16'd300, 8'd0, 16'd0));
		send_header(mk(8'd7, 8'd10, 8'd1, 8'd2, 16'd300, 8'd0, 16'd0));
		send_header(mk(8'd7, 8'd9, 8'd1, 8'd7, 16'd300, 8'd0, 16'd0));
		send_header(mk(8'd7, 8'd9, 8'd1, 8'd4, 16'd300, 8'd0, 16'd0));
		send_header(mk(8'd200, 8'd3, 8'd4, 8'hff, 16'd0, 8'd1, 16'h1234));
		send_header(mk(8'd200, 8'd3, 8'd4, 8'hff, 16'hffff, 8'd2, 16'h1234));
		send_header(mk(8'd200, 8'd255, 8'd255, 8'hff, 16'd0, 8'hff, 16'hffff));
		send_header(mk(8'd200, 8'd255, 8'd255, 8'hff, 16'd0, 8'd0, 16'd0));
		send_header(mk(8'd200, 8'd255, 8'd255, 8'd254, 16'hffff, 8'd0, 16'd0));
	endtask

	task automatic run_random(input int n);
		int sent;
		int r;
		int k;
		int maxf;
		bit stop;
		header_t h;
		header_t base;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(0, 3) == 0) begin
				h = random_header();
				if ($urandom_range(0, 3) == 0)
					h.typ = sb.raw_types[$urandom_range(0, 2)];
				send_header(h);
				sent++;
			end else begin
				r = $urandom_range(0, 39);
				if (r == 0)
					maxf = 2 * $urandom_range(64, 127) + 1;
				else if (r < 6)
					maxf = 2 * $urandom_range(5, 15) + 1;
				else
					maxf = 2 * $urandom_range(0, 4) + 1;
				base = random_header();
				if ($urandom_range(0, 3) != 0)
					base.src = 8'($urandom_range(0, 7));
				base.typ = sb.pick_plain_type();
				send_header(fragment(base, 8'(maxf)));
				sent++;
				stop = 1'b0;
				for (k = 2; k <= maxf + 1 && k <= 254 && !stop; k += 2) begin
					h = fragment(base, 8'(k));
					r = $urandom_range(0, 29);
					case (r)
						0: begin
							h.seq ^= 16'(1) << $urandom_range(0, 15);
							h.xseq ^= 16'(1) << $urandom_range(0, 15);
						end
						1: h.typ ^= 8'(1) << $urandom_range(0, 7);
						2: h.dst ^= 8'(1) << $urandom_range(0, 7);
						3: h = fragment(base, 8'(k + 2));
						default: ;
					endcase
					if (r <= 3)
						stop = 1'b1;
					// Abandoned train: the next first fragment discards it.
					if (r != 4) begin
						send_header(h);
						sent++;
					end else begin
						stop = 1'b1;
					end
					if (r == 5) begin
						send_header(h);
						sent++;
					end
				end
			end
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= 2'd0;
		cfg_data <= 8'd0;
		in_valid <= 1'b0;
		source_address <= 8'd0;
		dest_address <= 8'd0;
		frame_type <= 8'd0;
		split_flag <= 8'd0;
		sequence_id <= 16'd0;
		ext_split_flag <= 8'd0;
		ext_sequence_id <= 16'd0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		settle();
		write_type_regs(8'd0, 8'd255, 8'd0);
		run_random(100);
		settle();
		write_type_regs(8'($urandom), 8'($urandom), 8'($urandom));
		run_random(100);
		settle();
		write_type_regs(8'd255, 8'd255, 8'd255);
		run_random(100);
		settle();
		write_type_regs(8'($urandom), 8'($urandom), 8'($urandom));
		calm = 1'b1;
		run_random(100);
		settle();
		repeat (8) @(posedge clk);

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
